/* src/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit bitmap allocator files.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int OP_W    = 1;
    localparam int SIZE_W  = 15;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_BAD     = 2'd2
    } ffba_status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RANGE,
        S_MARK0,
        S_MARK,
        S_RESP
    } ffba_state_t;

    typedef struct packed {
        logic         clear_step;
        logic         load;
        logic         scan_start;
        logic         scan_step;
        logic         range_alloc;
        logic         range_free;
        logic         mark_start;
        logic         mark_step;
        logic         code_we;
        ffba_status_t code;
        logic         push;
    } ffba_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic req_bad;
        logic req_free;
        logic free_oob;
        logic scan_hit;
        logic scan_last;
        logic mark_last;
        logic out_busy;
    } ffba_stat_t;

endpackage

/* src/ffba_if.sv */
// ----------------------------------------------------------------------------
// ffba channel interfaces
// Request, response and configuration write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface ffba_req_if
    import ffba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] free_address;

    modport source (output valid, output operation, output size_bytes,
                    output free_address, input ready);
    modport sink   (input valid, input operation, input size_bytes,
                    input free_address, output ready);
endinterface

interface ffba_rsp_if
    import ffba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] block_address;
    logic [STAT_W-1:0] status;

    modport source (output valid, output block_address, output status, input ready);
    modport sink   (input valid, input block_address, input status, output ready);
endinterface

interface ffba_cfg_if
    import ffba_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: clearing pass, request check, map scan, run marking, response.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ffba_stat_t stat,
    output ffba_cmd_t  cmd
);

    ffba_state_t state_reg;
    ffba_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.req_bad || (stat.req_free && stat.free_oob))
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = STAT_BAD;
                    state_next  = S_RESP;
                end
                else if (stat.req_free)
                begin
                    cmd.range_free = 1'b1;
                    state_next     = S_MARK0;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = S_RANGE;
                end
                else if (stat.scan_last)
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = STAT_NOSPACE;
                    state_next  = S_RESP;
                end
            end
            S_RANGE:
            begin
                cmd.range_alloc = 1'b1;
                state_next      = S_MARK0;
            end
            S_MARK0:
            begin
                cmd.mark_start = 1'b1;
                state_next     = S_MARK;
            end
            S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (stat.mark_last)
                begin
                    cmd.code_we = 1'b1;
                    cmd.code    = STAT_OK;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* src/ffba_datapath.sv */
// ----------------------------------------------------------------------------
// ffba_datapath
// Allocation map memory, scan run counter, range and mask logic, result reg.
// ----------------------------------------------------------------------------
module ffba_datapath
    import ffba_pkg::*;
#(
    parameter int MAP_BYTES     = 512,
    parameter int GRANULE_SHIFT = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ffba_cmd_t         cmd,
    output ffba_stat_t        stat,
    input  logic [OP_W-1:0]   in_operation,
    input  logic [SIZE_W-1:0] in_size_bytes,
    input  logic [ADDR_W-1:0] in_free_address,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] out_block_address,
    output logic [STAT_W-1:0] out_status
);

    localparam int TOTAL = MAP_BYTES * 8;
    localparam int AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int GW    = AW + 3;
    localparam int NW    = SIZE_W + 1;
    localparam int MW    = (NW > GW + 1) ? NW : GW + 1;
    localparam int WW    = ADDR_W + 2;
    localparam int GMASK = (1 << GRANULE_SHIFT) - 1;
    localparam logic [AW-1:0] LAST = AW'(MAP_BYTES - 1);

    logic [7:0]        map_mem [MAP_BYTES];
    logic [7:0]        rdata_reg;

    logic [AW-1:0]     ptr_reg;
    logic [MW-1:0]     run_reg;
    logic [GW-1:0]     hit_g_reg;
    logic [GW-1:0]     lo_reg;
    logic [GW-1:0]     hi_reg;
    logic [OP_W-1:0]   op_reg;
    logic [NW-1:0]     n_reg;
    logic [ADDR_W-1:0] offset_reg;
    logic [ADDR_W-1:0] region_base_reg;
    ffba_status_t      code_reg;
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [STAT_W-1:0] out_status_reg;

    logic [NW-1:0]     n_next;
    logic [ADDR_W-1:0] start_g;
    logic [GW-1:0]     n_m1;
    logic [MW-1:0]     n_ext;
    logic [MW-1:0]     run_next;
    logic              hit;
    logic [2:0]        hit_bit;
    logic [AW-1:0]     lo_byte;
    logic [AW-1:0]     hi_byte;
    logic [7:0]        mask;
    logic [7:0]        mark_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;

    // request decode
    assign n_next  = NW'(({1'b0, in_size_bytes} + NW'(GMASK)) >> GRANULE_SHIFT);
    assign start_g = offset_reg >> GRANULE_SHIFT;
    assign n_m1    = GW'(n_reg - 1'b1);
    assign n_ext   = MW'(n_reg);

    assign stat.req_bad  = (n_reg == '0) || (WW'(n_reg) > WW'(TOTAL));
    assign stat.req_free = (op_reg == OP_FREE);
    assign stat.free_oob = (WW'(start_g) + WW'(n_reg)) > WW'(TOTAL);

    // one map byte per cycle through the run counter, lowest bit first
    always_comb
    begin
        run_next = run_reg;
        hit      = 1'b0;
        hit_bit  = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (!hit)
            begin
                if (rdata_reg[b])
                begin
                    run_next = '0;
                end
                else
                begin
                    run_next = run_next + 1'b1;
                end
                if (run_next == n_ext)
                begin
                    hit     = 1'b1;
                    hit_bit = 3'(b);
                end
            end
        end
    end

    assign stat.scan_hit  = cmd.scan_step && hit;
    assign stat.scan_last = (ptr_reg == LAST);

    // partial masks at the first and last byte of the run
    assign lo_byte = lo_reg[GW-1:3];
    assign hi_byte = hi_reg[GW-1:3];

    always_comb
    begin
        mask = 8'hFF;
        if (ptr_reg == lo_byte)
        begin
            mask = mask & (8'hFF << lo_reg[2:0]);
        end
        if (ptr_reg == hi_byte)
        begin
            mask = mask & (8'hFF >> (3'd7 - hi_reg[2:0]));
        end
        if (op_reg == OP_FREE)
        begin
            mark_data = rdata_reg & ~mask;
        end
        else
        begin
            mark_data = rdata_reg | mask;
        end
    end

    assign stat.mark_last  = (ptr_reg == hi_byte);
    assign stat.clear_last = (ptr_reg == LAST);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // memory ports: write current byte, read the next one
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = ptr_reg + 1'b1;
        if (cmd.scan_start)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (cmd.mark_start)
        begin
            rd_en   = 1'b1;
            rd_addr = lo_byte;
        end
        else if (cmd.scan_step)
        begin
            rd_en = !stat.scan_last;
        end
        else if (cmd.mark_step)
        begin
            rd_en = !stat.mark_last;
        end
    end

    assign wr_en   = cmd.clear_step || cmd.mark_step;
    assign wr_addr = ptr_reg;
    assign wr_data = cmd.clear_step ? 8'h00 : mark_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg         <= '0;
            region_base_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.mark_start)
            begin
                ptr_reg <= lo_byte;
            end
            else if (cmd.clear_step || cmd.scan_step || cmd.mark_step)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                region_base_reg <= cfg_data;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_operation;
            n_reg      <= n_next;
            offset_reg <= in_free_address - region_base_reg;
        end
        if (cmd.scan_start)
        begin
            run_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            run_reg <= run_next;
        end
        if (stat.scan_hit)
        begin
            hit_g_reg <= {ptr_reg, hit_bit};
        end
        if (cmd.range_alloc)
        begin
            lo_reg <= hit_g_reg - n_m1;
            hi_reg <= hit_g_reg;
        end
        else if (cmd.range_free)
        begin
            lo_reg <= start_g[GW-1:0];
            hi_reg <= start_g[GW-1:0] + n_m1;
        end
        if (cmd.code_we)
        begin
            code_reg <= cmd.code;
        end
        if (cmd.push)
        begin
            out_status_reg <= code_reg;
            if (code_reg == STAT_OK && op_reg == OP_ALLOC)
            begin
                out_addr_reg <= region_base_reg + (ADDR_W'(lo_reg) << GRANULE_SHIFT);
            end
            else
            begin
                out_addr_reg <= '0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_block_address = out_addr_reg;
    assign out_status        = out_status_reg;

    // a pending response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.out_busy)
        else $error("response overwritten while stalled");

    // marking stays inside the range's bytes
    a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark_step |-> (ptr_reg >= lo_byte) && (ptr_reg <= hi_byte))
        else $error("mark pointer left the run");

    // a loaded range is never empty or reversed
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.range_alloc || cmd.range_free) |=> (lo_reg <= hi_reg))
        else $error("range start past range end");

    // clearing and marking never share the write port
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_step && (cmd.mark_step || cmd.scan_step)))
        else $error("clearing pass overlaps request work");

endmodule

/* src/first_fit_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator
// First-fit heap allocator over a one-bit-per-granule allocation map.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   operation, size_bytes, free_address
//  rsp      out  valid/ready   block_address, status
//  cfg      in   valid/ready   data (region_base)
//
//  From a req transfer to rsp.valid: allocate passes check, a scan of the bytes up
//  to the fitting run, range, mark start, marking of the bytes in the run and resp;
//  free passes check, mark start, marking and resp; bad size or address check and resp. Idle before the next req.
//  The map memory's single read port sets one byte a cycle.
//  After reset a clearing pass writes every map byte with
//  req.ready low; cfg transfers are taken throughout (cfg.ready is always high).
//  A response waits in the output register while rsp is stalled; the next
//  request is taken meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator
    import ffba_pkg::*;
#(
    parameter int MAP_BYTES     = 512,
    parameter int GRANULE_SHIFT = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    ffba_req_if.sink   req,
    ffba_rsp_if.source rsp,
    ffba_cfg_if.sink   cfg
);

    ffba_cmd_t  cmd;
    ffba_stat_t stat;

    assign cfg.ready = 1'b1;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffba_datapath #(
        .MAP_BYTES     (MAP_BYTES),
        .GRANULE_SHIFT (GRANULE_SHIFT)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_operation      (req.operation),
        .in_size_bytes     (req.size_bytes),
        .in_free_address   (req.free_address),
        .cfg_we            (cfg.valid),
        .cfg_data          (cfg.data),
        .out_valid         (rsp.valid),
        .out_ready         (rsp.ready),
        .out_block_address (rsp.block_address),
        .out_status        (rsp.status)
    );

endmodule

/* tb/tb_first_fit_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// tb_first_fit_bitmap_allocator
// Self-checking bench for the first-fit bitmap allocator. A directed table
// covers the error codes, whole-map and last-granule requests, misaligned
// and repeated frees. Random phases then follow at several region_base
// values and idle/stall mixes, mostly alloc/free pairs with some noise.
// Every response is checked against its table entry or a granule-level model of the map.
// ----------------------------------------------------------------------------
module tb_first_fit_bitmap_allocator;
    import ffba_pkg::*;

    localparam int MAP_BYTES      = 512;
    localparam int GRANULE_SHIFT  = 2;
    localparam int TOTAL_GRANULES = MAP_BYTES * 8;
    localparam int CYCLE_LIMIT    = 4_000_000;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 95;
    localparam int MAX_PRINTS     = 40;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        ffba_status_t      status;
    } alloc_result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic              fixed;
        alloc_result_t     want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();
    ffba_cfg_if cfg_ch ();

    first_fit_bitmap_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // model state: one bit per granule, set = in use
    logic [TOTAL_GRANULES-1:0] granule_busy;
    logic [ADDR_W-1:0]         base_model;

    alloc_result_t     pending_results[$];
    logic [ADDR_W-1:0] live_addr[$];
    int unsigned       live_size[$];

    script_row_t script_rows [24];

    int unsigned req_idle_pct  = 0;
    int unsigned rsp_stall_pct = 0;
    int unsigned error_count   = 0;
    int unsigned results_seen  = 0;
    int unsigned cycle_count   = 0;

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH @%0t result %0d: %s", $time, results_seen, what);
        error_count++;
    endtask

    function automatic alloc_result_t model_request(input logic [OP_W-1:0] op,
                                                    input logic [SIZE_W-1:0] size,
                                                    input logic [ADDR_W-1:0] addr);
        alloc_result_t     r;
        int unsigned       n;
        int unsigned       run;
        int unsigned       first;
        logic [ADDR_W-1:0] offset;
        longint unsigned   start;
        r.block_address = '0;
        r.status        = STAT_BAD;
        n = (int'(size) + (1 << GRANULE_SHIFT) - 1) >> GRANULE_SHIFT;
        if (size == 0 || n > TOTAL_GRANULES)
            return r;
        if (op == OP_ALLOC)
        begin
            run = 0;
            for (int g = 0; g < TOTAL_GRANULES; g++)
            begin
                if (granule_busy[g])
                    run = 0;
                else
                begin
                    run++;
                    if (run == n)
                    begin
                        first = g + 1 - n;
                        for (int k = first; k <= g; k++)
                            granule_busy[k] = 1'b1;
                        r.block_address = base_model + (first << GRANULE_SHIFT);
                        r.status        = STAT_OK;
                        return r;
                    end
                end
            end
            r.status = STAT_NOSPACE;
            return r;
        end
        // offset wraps modulo 2^32, then truncates to whole granules
        offset = addr - base_model;
        start  = offset >> GRANULE_SHIFT;
        if (start + n > TOTAL_GRANULES)
            return r;
        for (longint unsigned g = start; g < start + n; g++)
            granule_busy[g] = 1'b0;
        r.status = STAT_OK;
        return r;
    endfunction

    // one request transfer; prediction happens at the accepting edge
    task automatic send_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] addr, input logic fixed,
                                input alloc_result_t want);
        alloc_result_t got;
        @(negedge clk);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.size_bytes   <= size;
        req_ch.free_address <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        got = model_request(op, size, addr);
        if (op == OP_ALLOC && got.status == STAT_OK)
        begin
            live_addr.push_back(got.block_address);
            live_size.push_back(size);
        end
        pending_results.push_back(fixed ? want : got);
    endtask

    task automatic drain_results;
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_region_base(input logic [ADDR_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        base_model = value;
        live_addr.delete();
        live_size.delete();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly alloc/free of live blocks; the rest partial frees and noise
    task automatic pick_random(output logic [OP_W-1:0] op, output logic [SIZE_W-1:0] size,
                               output logic [ADDR_W-1:0] addr);
        int unsigned roll;
        int unsigned idx;
        roll = $urandom_range(0, 99);
        op   = OP_ALLOC;
        size = SIZE_W'($urandom_range(1, 64));
        addr = $urandom;
        if (roll < 10)
            size = SIZE_W'($urandom_range(65, 4096));
        else if (roll >= 50 && roll < 78 && live_addr.size() != 0)
        begin
            idx  = $urandom_range(0, live_addr.size() - 1);
            op   = OP_FREE;
            size = SIZE_W'(live_size[idx]);
            addr = live_addr[idx];
            if ($urandom_range(0, 4) == 0)
                addr = addr + $urandom_range(1, 3);
            live_addr.delete(idx);
            live_size.delete(idx);
        end
        else if (roll >= 78 && roll < 86)
        begin
            op   = OP_FREE;
            size = SIZE_W'($urandom_range(1, 512));
            addr = base_model + ($urandom_range(0, TOTAL_GRANULES - 1) << GRANULE_SHIFT);
        end
        else if (roll >= 86 && roll < 94)
        begin
            op   = OP_W'($urandom_range(0, 1));
            size = SIZE_W'($urandom);
        end
        else if (roll >= 94)
        begin
            op   = OP_W'($urandom_range(0, 1));
            size = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(16385, 32767));
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected response addr %h status %0d",
                                          rsp_ch.block_address, rsp_ch.status));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.block_address !== want.block_address)
                    report_mismatch($sformatf("block_address %h, want %h",
                                              rsp_ch.block_address, want.block_address));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_ch.status, want.status));
            end
            results_seen++;
        end
    end

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [OP_W-1:0]   op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;

        req_ch.valid        = 1'b0;
        req_ch.operation    = OP_ALLOC;
        req_ch.size_bytes   = '0;
        req_ch.free_address = '0;
        rsp_ch.ready        = 1'b1;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        granule_busy        = '0;
        base_model          = '0;

        // region_base at its reset value 0 throughout the table
        script_rows = '{
            '{OP_ALLOC, 15'd0,     32'h0000_0000, 1'b1, '{32'd0, STAT_BAD}},
            '{OP_FREE,  15'd0,     32'h0000_0000, 1'b1, '{32'd0, STAT_BAD}},
            '{OP_ALLOC, 15'd32767, 32'hFFFF_FFFF, 1'b1, '{32'd0, STAT_BAD}},
            '{OP_ALLOC, 15'd16385, 32'h0000_0000, 1'b1, '{32'd0, STAT_BAD}},
            '{OP_FREE,  15'd32767, 32'h0000_0000, 1'b1, '{32'd0, STAT_BAD}},
            '{OP_ALLOC, 15'd16384, 32'h0000_0000, 1'b1, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd1,     32'h0000_0000, 1'b1, '{32'd0, STAT_NOSPACE}},
            '{OP_FREE,  15'd4,     32'hFFFF_FFFF, 1'b1, '{32'd0, STAT_BAD}},
            '{OP_FREE,  15'd16384, 32'h0000_0004, 1'b1, '{32'd0, STAT_BAD}},
            '{OP_FREE,  15'd16384, 32'h0000_0000, 1'b1, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd1,     32'h0000_0000, 1'b1, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd5,     32'h0000_0000, 1'b0, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd3,     32'h0000_0000, 1'b0, '{32'd0, STAT_OK}},
            '{OP_FREE,  15'd8,     32'h0000_0006, 1'b0, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd8,     32'h0000_0000, 1'b0, '{32'd0, STAT_OK}},
            '{OP_FREE,  15'd4,     32'h0000_0190, 1'b0, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd16380, 32'h0000_0000, 1'b0, '{32'd0, STAT_OK}},
            '{OP_FREE,  15'd16384, 32'h0000_0000, 1'b1, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd16380, 32'h0000_0000, 1'b1, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd4,     32'h0000_0000, 1'b1, '{32'd16380, STAT_OK}},
            '{OP_ALLOC, 15'd4,     32'h0000_0000, 1'b1, '{32'd0, STAT_NOSPACE}},
            '{OP_FREE,  15'd4,     32'h0000_3FFC, 1'b1, '{32'd0, STAT_OK}},
            '{OP_ALLOC, 15'd2,     32'h0000_0000, 1'b1, '{32'd16380, STAT_OK}},
            '{OP_FREE,  15'd16384, 32'h0000_0000, 1'b1, '{32'd0, STAT_OK}}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script_rows[i])
            send_request(script_rows[i].op, script_rows[i].size, script_rows[i].addr,
                         script_rows[i].fixed, script_rows[i].want);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  base = 32'hFFFF_FFFF; end
                1: begin req_idle_pct = 82; rsp_stall_pct = 0;  base = $urandom;      end
                2: begin req_idle_pct = 0;  rsp_stall_pct = 82; base = 32'hFFFF_F000; end
                3: begin req_idle_pct = 9;  rsp_stall_pct = 9;  base = 32'h0000_0000; end
                4: begin req_idle_pct = 0;  rsp_stall_pct = 82; base = $urandom;      end
                default: begin req_idle_pct = 9; rsp_stall_pct = 9; base = $urandom; end
            endcase
            write_region_base(base);
            // start each phase from an empty map
            send_request(OP_FREE, 15'd16384, base, 1'b0, '0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == PHASE_ITEMS / 2)
                    drain_results();
                pick_random(op, size, addr);
                send_request(op, size, addr, 1'b0, '0);
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
